// ===== sv/tbm_pkg.sv =====
// Types, codes and sizes shared by the triple buffer frame manager.
package tbm_pkg;

  localparam int BUFFER_COUNT = 3;
  localparam int BUF_IDX_W = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int IDX_W = 3;
  localparam int SHOWN_W = 4;
  localparam int STAMP_W = 32;
  localparam int TIME_W = 48;
  localparam int CFG_W = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [SHOWN_W-1:0] NONE_SHOWN = 4'd15;

  localparam logic [2:0] KIND_ACQUIRE      = 3'd0;
  localparam logic [2:0] KIND_PUBLISH      = 3'd1;
  localparam logic [2:0] KIND_ABORT        = 3'd2;
  localparam logic [2:0] KIND_PRESENT_TICK = 3'd3;
  localparam logic [2:0] KIND_PRESENT_DONE = 3'd4;

  localparam logic [2:0] RES_OK            = 3'd0;
  localparam logic [2:0] RES_PACED         = 3'd1;
  localparam logic [2:0] RES_NO_FREE       = 3'd2;
  localparam logic [2:0] RES_NOTHING_READY = 3'd3;
  localparam logic [2:0] RES_DISABLED      = 3'd4;
  localparam logic [2:0] RES_IGNORED       = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PACING_TOL     = 2'd2;

  localparam logic [CFG_W-1:0] FRAME_PERIOD_RESET = 20'd33333;
  localparam logic [CFG_W-1:0] PACING_TOL_RESET   = 20'd3000;

  typedef enum logic [1:0] {
    BUF_FREE      = 2'd0,
    BUF_WRITING   = 2'd1,
    BUF_READY     = 2'd2,
    BUF_DISPLAYED = 2'd3
  } buf_state_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [TIME_W-1:0] now_us;
    logic [IDX_W-1:0]  buffer_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [IDX_W-1:0]   granted_index;
    logic [STAMP_W-1:0] sequence_res;
  } out_item_t;

  typedef struct packed {
    logic             present_enable;
    logic [CFG_W-1:0] frame_period_us;
    logic [CFG_W-1:0] pacing_tolerance_us;
  } cfg_t;

  typedef struct packed {
    buf_state_t [BUFFER_COUNT-1:0]              buffer_status;
    logic [BUFFER_COUNT-1:0][STAMP_W-1:0]       buffer_stamp;
    logic [STAMP_W-1:0]                         stamp_counter;
    logic [TIME_W-1:0]                          next_deadline;
    logic                                       deadline_armed;
    logic [SHOWN_W-1:0]                         shown_index;
  } mgr_state_t;

endpackage

// ===== sv/tbm_event_logic.sv =====
// Single-pass event decode and buffer pool update for one request.
module tbm_event_logic import tbm_pkg::*; (
  input  in_item_t   req,
  input  cfg_t       cfg,
  input  mgr_state_t cur,
  output mgr_state_t nxt,
  output out_item_t  res
);

  logic                 free_found;
  logic [BUF_IDX_W-1:0] free_idx;
  logic                 sel_found;
  logic [BUF_IDX_W-1:0] sel_idx;
  logic [STAMP_W-1:0]   best;
  logic [TIME_W:0]      tol_sum;
  logic [TIME_W:0]      period_sum;
  logic [TIME_W-1:0]    deadline_sat;
  logic                 paced;
  logic                 bi_ok;
  logic [BUF_IDX_W-1:0] bi;
  logic                 shown_ok;
  logic [BUF_IDX_W-1:0] shown;
  logic [STAMP_W-1:0]   stamp_inc;

  assign tol_sum      = {1'b0, req.now_us} + (TIME_W+1)'(cfg.pacing_tolerance_us);
  assign period_sum   = {1'b0, req.now_us} + (TIME_W+1)'(cfg.frame_period_us);
  assign deadline_sat = period_sum[TIME_W] ? '1 : period_sum[TIME_W-1:0];
  assign paced        = cur.deadline_armed && (tol_sum < {1'b0, cur.next_deadline});
  assign bi           = req.buffer_index[BUF_IDX_W-1:0];
  assign bi_ok        = ({1'b0, req.buffer_index} < (IDX_W+1)'(BUFFER_COUNT))
                        && (cur.buffer_status[bi] == BUF_WRITING);
  assign shown        = cur.shown_index[BUF_IDX_W-1:0];
  assign shown_ok     = cur.shown_index < SHOWN_W'(BUFFER_COUNT);
  assign stamp_inc    = cur.stamp_counter + 1'b1;

  // lowest free buffer
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < BUFFER_COUNT; i++) begin
      if (!free_found && cur.buffer_status[i] == BUF_FREE) begin
        free_found = 1'b1;
        free_idx   = BUF_IDX_W'(i);
      end
    end
  end

  // newest ready buffer, lowest index on ties
  always_comb begin
    sel_found = 1'b0;
    sel_idx   = '0;
    best      = '0;
    for (int i = 0; i < BUFFER_COUNT; i++) begin
      if (cur.buffer_status[i] == BUF_READY &&
          (!sel_found || cur.buffer_stamp[i] > best)) begin
        sel_found = 1'b1;
        sel_idx   = BUF_IDX_W'(i);
        best      = cur.buffer_stamp[i];
      end
    end
  end

  always_comb begin
    nxt = cur;
    res = '{status: RES_IGNORED, granted_index: '0, sequence_res: '0};
    unique case (req.kind) inside
      KIND_ACQUIRE: begin
        if (paced) begin
          res.status = RES_PACED;
        end else begin
          nxt.next_deadline  = deadline_sat;
          nxt.deadline_armed = 1'b1;
          if (free_found) begin
            nxt.buffer_status[free_idx] = BUF_WRITING;
            res.status        = RES_OK;
            res.granted_index = IDX_W'(free_idx);
          end else begin
            res.status = RES_NO_FREE;
          end
        end
      end
      KIND_PUBLISH, KIND_ABORT: begin
        if (bi_ok) begin
          res.status        = RES_OK;
          res.granted_index = req.buffer_index;
          if (req.kind == KIND_ABORT) begin
            nxt.buffer_status[bi] = BUF_FREE;
          end else begin
            for (int i = 0; i < BUFFER_COUNT; i++) begin
              if (cur.buffer_status[i] == BUF_READY) begin
                nxt.buffer_status[i] = BUF_FREE;
              end
            end
            nxt.stamp_counter     = stamp_inc;
            nxt.buffer_stamp[bi]  = stamp_inc;
            nxt.buffer_status[bi] = BUF_READY;
            res.sequence_res      = stamp_inc;
          end
        end
      end
      KIND_PRESENT_TICK: begin
        if (!cfg.present_enable) begin
          res.status = RES_DISABLED;
        end else if (!sel_found) begin
          res.status = RES_NOTHING_READY;
        end else begin
          if (shown_ok && cur.buffer_status[shown] == BUF_DISPLAYED) begin
            nxt.buffer_status[shown] = BUF_FREE;
          end
          nxt.buffer_status[sel_idx] = BUF_DISPLAYED;
          nxt.shown_index            = SHOWN_W'(sel_idx);
          res.status                 = RES_OK;
          res.granted_index          = IDX_W'(sel_idx);
          res.sequence_res           = best;
        end
      end
      KIND_PRESENT_DONE: begin
        if (shown_ok) begin
          nxt.buffer_status[shown] = BUF_FREE;
          nxt.shown_index          = NONE_SHOWN;
          res.status               = RES_OK;
          res.granted_index        = IDX_W'(shown);
          res.sequence_res         = cur.buffer_stamp[shown];
        end
      end
      default: begin
        res.status = RES_IGNORED;
      end
    endcase
  end

endmodule

// ===== sv/triple_buffer_latest_frame_manager_top.sv =====
// Top level: request register, pool state, configuration and result register.
//
//   channel | ports                                  | moves
//   --------+----------------------------------------+--------------------------
//   in      | in_valid, in_ready, in_data            | one event request
//   out     | out_valid, out_ready, out_data         | one result per request
//   cfg     | cfg_write_en, cfg_index, cfg_wdata     | register write, no wait
//
// One request per cycle sustained while out_ready is high.
// The request register feeds the single-pass update, which loads the result
// register and the pool state in the same cycle.
// Synchronous reset frees all buffers, clears stamps and deadline, and loads
// the configuration reset values.
// While out_ready is low the result holds, one more request waits in the
// request register, and then in_ready drops.
module triple_buffer_latest_frame_manager_top import tbm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic       in_v_r;
  in_item_t   in_r;
  logic       out_v_r;
  out_item_t  out_r;
  mgr_state_t state_r;
  mgr_state_t state_nxt;
  out_item_t  res_nxt;
  cfg_t       cfg_r;
  logic       advance;
  logic [BUFFER_COUNT-1:0] displayed;

  assign advance   = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || advance;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  tbm_event_logic u_event (
    .req (in_r),
    .cfg (cfg_r),
    .cur (state_r),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        state_r.buffer_status[i] <= BUF_FREE;
        state_r.buffer_stamp[i]  <= '0;
      end
      state_r.stamp_counter  <= '0;
      state_r.next_deadline  <= '0;
      state_r.deadline_armed <= 1'b0;
      state_r.shown_index    <= NONE_SHOWN;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.present_enable      <= 1'b0;
      cfg_r.frame_period_us     <= FRAME_PERIOD_RESET;
      cfg_r.pacing_tolerance_us <= PACING_TOL_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_PRESENT_ENABLE: cfg_r.present_enable      <= cfg_wdata[0];
        CFG_FRAME_PERIOD:   cfg_r.frame_period_us     <= cfg_wdata;
        CFG_PACING_TOL:     cfg_r.pacing_tolerance_us <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < BUFFER_COUNT; i++) begin
      displayed[i] = (state_r.buffer_status[i] == BUF_DISPLAYED);
    end
  end

  a_one_displayed: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(displayed) <= 1)
    else $error("more than one buffer on display");

  a_shown_is_displayed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.shown_index < SHOWN_W'(BUFFER_COUNT)) |->
      (state_r.buffer_status[state_r.shown_index[BUF_IDX_W-1:0]] == BUF_DISPLAYED))
    else $error("shown buffer not in displayed state");

  a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.shown_index == NONE_SHOWN) || (state_r.shown_index < SHOWN_W'(BUFFER_COUNT)))
    else $error("shown index out of range");

  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(state_r.stamp_counter)) |->
      (state_r.stamp_counter == $past(state_r.stamp_counter) + 32'd1))
    else $error("stamp counter moved by other than one");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ready)
    else $error("request stalled with empty result register");

endmodule
